FILE: sv/etm_pkg.sv
// ----------------------------------------------------------------------------
// etm_pkg
// Types, register offsets and bit positions for the one-comparator event timer
// ----------------------------------------------------------------------------
package etm_pkg;

	localparam int unsigned CNT_W    = 64;
	localparam int unsigned IDX_W    = 6;
	localparam int unsigned ACT_W    = 2;
	localparam int unsigned PERIOD_W = 27;
	localparam int unsigned VENDOR_W = 16;
	localparam int unsigned REV_W    = 8;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 27;
	localparam int unsigned IN_TDATA_W  = 72;
	localparam int unsigned OUT_TDATA_W = 72;

	// actions
	localparam logic [ACT_W-1:0] ACT_TICK  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_WRITE = 2'd2;

	// register indices (byte offset / 8)
	localparam logic [IDX_W-1:0] IDX_CAPS    = 6'(12'h000 >> 3);
	localparam logic [IDX_W-1:0] IDX_GEN_CFG = 6'(12'h010 >> 3);
	localparam logic [IDX_W-1:0] IDX_INT_STS = 6'(12'h020 >> 3);
	localparam logic [IDX_W-1:0] IDX_COUNTER = 6'(12'h0F0 >> 3);
	localparam logic [IDX_W-1:0] IDX_T0_CFG  = 6'(12'h100 >> 3);
	localparam logic [IDX_W-1:0] IDX_T0_CMP  = 6'(12'h108 >> 3);

	// configuration register indices
	localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDE_CNT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LEGACY_CAP  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_VENDOR      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_REVISION    = 3'd4;

	localparam logic [PERIOD_W-1:0] RST_TICK_PERIOD = 27'd69841279;
	localparam logic [VENDOR_W-1:0] RST_VENDOR      = 16'd32902;
	localparam logic [REV_W-1:0]    RST_REVISION    = 8'd1;

	// timer 0 config bit positions
	localparam int unsigned TCFG_LEVEL    = 1;
	localparam int unsigned TCFG_INT_EN   = 2;
	localparam int unsigned TCFG_PERIODIC = 3;
	localparam int unsigned TCFG_PER_CAP  = 4;
	localparam int unsigned TCFG_WIDE_CAP = 5;
	localparam int unsigned TCFG_VAL_SET  = 6;

	localparam logic [CNT_W-1:0] MASK_NARROW = 64'h0000_0000_FFFF_FFFF;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic [IDX_W-1:0] reg_index;
		logic [CNT_W-1:0] write_data;
	} item_t;

	typedef struct packed {
		logic [CNT_W-1:0] read_data;
		logic             irq_level;
		logic             matched;
	} result_t;

	typedef struct packed {
		logic                  we;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

endpackage

FILE: sv/event_timer_one_comparator_unit.sv
// ----------------------------------------------------------------------------
// event_timer_one_comparator_unit
// High precision event timer with one comparator, stream transaction wrapper
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  s_axis   | in        | tdata: reg_index, write_data; tuser: action
//  m_axis   | out       | tdata: read_data, irq_level, matched
//  cfg      | in        | write enable, register index, write data
//
//  one transaction per cycle sustained while m_axis accepts; input and result registers lie between s_axis and m_axis
//  the input register feeds the timer state update and result register in the same cycle
//  reset clears the timer state and returns configuration to its defaults
//  a stalled m_axis holds the result; an empty input register takes one more
//  transaction, then s_axis_tready stays low until m_axis drains
// ----------------------------------------------------------------------------
module event_timer_one_comparator_unit import etm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // reg_index, write_data, zero pad
	input  logic [ACT_W-1:0]       s_axis_tuser,  // action
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // read_data, irq_level, matched, zero pad
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic    valid_s1;
	item_t   item_s1;
	logic    out_valid_q;
	result_t out_q;
	logic    advance;
	logic    fire;
	cfg_wr_t cfg_wr;
	result_t res;

	assign advance       = !out_valid_q || m_axis_tready;
	assign fire          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	assign cfg_wr.we    = cfg_we;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (advance)
				out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.action     <= s_axis_tuser;
			item_s1.reg_index  <= s_axis_tdata[IDX_W-1:0];
			item_s1.write_data <= s_axis_tdata[IDX_W+CNT_W-1:IDX_W];
		end
		if (fire)
			out_q <= res;
	end

	etm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_wr (cfg_wr),
		.fire   (fire),
		.item   (item_s1),
		.res    (res)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, out_q.matched, out_q.irq_level, out_q.read_data};

endmodule

FILE: sv/etm_core.sv
// ----------------------------------------------------------------------------
// etm_core
// Timer state, configuration registers and transaction handling
// ----------------------------------------------------------------------------
module etm_core import etm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_wr_t cfg_wr,
	input  logic    fire,
	input  item_t   item,
	output result_t res
);

	logic [PERIOD_W-1:0] tick_period_q;
	logic                wide_q;
	logic                legacy_cap_q;
	logic [VENDOR_W-1:0] vendor_q;
	logic [REV_W-1:0]    revision_q;

	logic [CNT_W-1:0] main_count_q, main_count_d;
	logic [CNT_W-1:0] compare_q, compare_d;
	logic [CNT_W-1:0] period_q, period_d;
	logic global_en_q, global_en_d;
	logic legacy_route_q, legacy_route_d;
	logic int_en_q, int_en_d;
	logic periodic_q, periodic_d;
	logic value_set_q, value_set_d;
	logic level_q, level_d;
	logic int_status_q, int_status_d;

	logic [CNT_W-1:0] mask;
	logic [CNT_W-1:0] count_inc;
	logic [CNT_W-1:0] cmp_add;
	logic [CNT_W-1:0] wd_masked;
	logic [CNT_W-1:0] rd;
	logic             hit;
	logic             route_clear;

	assign mask        = wide_q ? '1 : MASK_NARROW;
	assign count_inc   = (main_count_q + CNT_W'(1)) & mask;
	assign cmp_add     = (compare_q + period_q) & mask;
	assign wd_masked   = item.write_data & mask;
	assign route_clear = cfg_wr.we && (cfg_wr.index == CFG_LEGACY_CAP) && !cfg_wr.data[0];

	always_comb begin
		main_count_d   = main_count_q;
		compare_d      = compare_q;
		period_d       = period_q;
		global_en_d    = global_en_q;
		legacy_route_d = legacy_route_q;
		int_en_d       = int_en_q;
		periodic_d     = periodic_q;
		value_set_d    = value_set_q;
		level_d        = level_q;
		int_status_d   = int_status_q;
		rd             = '0;
		hit            = 1'b0;
		unique case (item.action)
			ACT_TICK: begin
				if (global_en_q) begin
					main_count_d = count_inc;
					if (count_inc == (compare_q & mask)) begin
						hit          = 1'b1;
						int_status_d = 1'b1;
						if (periodic_q)
							compare_d = cmp_add;
					end
				end
			end
			ACT_READ: begin
				unique case (item.reg_index)
					IDX_CAPS: rd = {5'b0, tick_period_q, vendor_q, legacy_cap_q, 1'b0,
						wide_q, 5'b0, revision_q};
					IDX_GEN_CFG: rd = {62'b0, legacy_route_q, global_en_q};
					IDX_INT_STS: rd = {63'b0, int_status_q};
					IDX_COUNTER: rd = main_count_q & mask;
					IDX_T0_CFG: begin
						rd[TCFG_LEVEL]    = level_q;
						rd[TCFG_INT_EN]   = int_en_q;
						rd[TCFG_PERIODIC] = periodic_q;
						rd[TCFG_PER_CAP]  = 1'b1;
						rd[TCFG_WIDE_CAP] = wide_q;
						rd[TCFG_VAL_SET]  = value_set_q;
					end
					IDX_T0_CMP: rd = compare_q & mask;
					default: rd = '0;
				endcase
			end
			ACT_WRITE: begin
				unique case (item.reg_index)
					IDX_GEN_CFG: begin
						global_en_d    = item.write_data[0];
						legacy_route_d = legacy_cap_q & item.write_data[1];
					end
					IDX_INT_STS: begin
						if (item.write_data[0])
							int_status_d = 1'b0;
					end
					IDX_COUNTER: main_count_d = wd_masked;
					IDX_T0_CFG: begin
						level_d     = item.write_data[TCFG_LEVEL];
						int_en_d    = item.write_data[TCFG_INT_EN];
						periodic_d  = item.write_data[TCFG_PERIODIC];
						value_set_d = item.write_data[TCFG_VAL_SET];
					end
					IDX_T0_CMP: begin
						if (!periodic_q || value_set_q)
							compare_d = wd_masked;
						period_d    = wd_masked;
						value_set_d = 1'b0;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		if (route_clear)
			legacy_route_d = 1'b0;
	end

	assign res.read_data = rd;
	assign res.irq_level = int_status_d & int_en_d;
	assign res.matched   = hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_period_q  <= RST_TICK_PERIOD;
			wide_q         <= 1'b1;
			legacy_cap_q   <= 1'b1;
			vendor_q       <= RST_VENDOR;
			revision_q     <= RST_REVISION;
			main_count_q   <= '0;
			compare_q      <= '1;
			period_q       <= '0;
			global_en_q    <= 1'b0;
			legacy_route_q <= 1'b0;
			int_en_q       <= 1'b0;
			periodic_q     <= 1'b0;
			value_set_q    <= 1'b0;
			level_q        <= 1'b0;
			int_status_q   <= 1'b0;
		end else begin
			if (fire) begin
				main_count_q   <= main_count_d;
				compare_q      <= compare_d;
				period_q       <= period_d;
				global_en_q    <= global_en_d;
				int_en_q       <= int_en_d;
				periodic_q     <= periodic_d;
				value_set_q    <= value_set_d;
				level_q        <= level_d;
				int_status_q   <= int_status_d;
			end
			if (fire || route_clear)
				legacy_route_q <= legacy_route_d;
			if (cfg_wr.we) begin
				unique case (cfg_wr.index)
					CFG_TICK_PERIOD: tick_period_q <= cfg_wr.data[PERIOD_W-1:0];
					CFG_WIDE_CNT:    wide_q        <= cfg_wr.data[0];
					CFG_LEGACY_CAP:  legacy_cap_q  <= cfg_wr.data[0];
					CFG_VENDOR:      vendor_q   <= cfg_wr.data[VENDOR_W-1:0];
					CFG_REVISION:    revision_q <= cfg_wr.data[REV_W-1:0];
					default: ;
				endcase
			end
		end
	end

	a_match_sets_status: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.matched |=> int_status_q)
		else $error("match did not set interrupt status");

	a_match_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		res.matched |-> (item.action == ACT_TICK) && global_en_q)
		else $error("match outside an enabled tick");

	a_route_needs_cap: assert property (@(posedge clk) disable iff (!arst_n)
		!legacy_cap_q |-> !legacy_route_q)
		else $error("legacy route set without capability");

	a_cmp_write_clears_set: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (item.action == ACT_WRITE) && (item.reg_index == IDX_T0_CMP)
		|=> !value_set_q)
		else $error("comparator write left value-set bit");

	a_read_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (item.action == ACT_READ) |=> $stable(main_count_q))
		else $error("read changed the main counter");

endmodule

FILE: test/tb_event_timer_one_comparator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_event_timer_one_comparator_unit
// Self-checking bench for the one-comparator event timer
// ----------------------------------------------------------------------------
// Bus reads, bus writes and counter ticks go in on s_axis. Each accepted
// transaction runs through a timer model held in the bench, and the reply it
// predicts is checked against m_axis in order. Directed tests cover the
// register map, match handling, legacy gating and the 32-bit counter. Random
// phases then run under several capability settings, extremes included, with
// random gaps on both sides and one stretch without any.
// ----------------------------------------------------------------------------
module tb_event_timer_one_comparator_unit;
	import etm_pkg::*;

	localparam logic [ACT_W-1:0]     ACT_NONE     = 2'd3;
	localparam logic [IDX_W-1:0]     IDX_SPARE    = 6'd1;
	localparam logic [IDX_W-1:0]     IDX_TOP      = 6'd63;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 3'd7;
	localparam int unsigned          CYCLE_LIMIT  = 200000;
	localparam int unsigned          PHASE_ITEMS  = 180;
	localparam int unsigned          PAD_W        = IN_TDATA_W - CNT_W - IDX_W;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;  // reg_index, write_data, zero pad
	logic [ACT_W-1:0]       s_axis_tuser = '0;  // action
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;       // read_data, irq_level, matched, zero pad
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// timer model: capability settings
	logic [PERIOD_W-1:0] tick_period;
	logic                counter_wide;
	logic                legacy_cap;
	logic [VENDOR_W-1:0] vendor_id;
	logic [REV_W-1:0]    revision_id;
	// timer model: state
	logic [CNT_W-1:0]    main_cnt;
	logic [CNT_W-1:0]    cmp_val;
	logic [CNT_W-1:0]    period_val;
	logic                enabled;
	logic                legacy_on;
	logic                irq_enable;
	logic                periodic_mode;
	logic                value_set;
	logic                level_mode;
	logic                irq_status;

	result_t     timer_replies[$];
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	bit          no_gaps = 1'b0;

	event_timer_one_comparator_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void reset_timer_model();
		tick_period   = RST_TICK_PERIOD;
		counter_wide  = 1'b1;
		legacy_cap    = 1'b1;
		vendor_id     = RST_VENDOR;
		revision_id   = RST_REVISION;
		main_cnt      = '0;
		cmp_val       = '1;
		period_val    = '0;
		enabled       = 1'b0;
		legacy_on     = 1'b0;
		irq_enable    = 1'b0;
		periodic_mode = 1'b0;
		value_set     = 1'b0;
		level_mode    = 1'b0;
		irq_status    = 1'b0;
	endfunction

	function automatic logic [CNT_W-1:0] count_mask();
		return counter_wide ? '1 : MASK_NARROW;
	endfunction

	function automatic void apply_setting(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] value);
		case (index)
		CFG_TICK_PERIOD: tick_period = value[PERIOD_W-1:0];
		CFG_WIDE_CNT:    counter_wide = value[0];
		CFG_LEGACY_CAP: begin
			legacy_cap = value[0];
			if (!legacy_cap)
				legacy_on = 1'b0;
		end
		CFG_VENDOR:      vendor_id = value[VENDOR_W-1:0];
		CFG_REVISION:    revision_id = value[REV_W-1:0];
		default: ;
		endcase
	endfunction

	function automatic logic [CNT_W-1:0] register_value(input logic [IDX_W-1:0] idx);
		logic [CNT_W-1:0] v;
		v = '0;
		case (idx)
		IDX_CAPS:    v = {5'd0, tick_period, vendor_id, legacy_cap, 1'b0, counter_wide,
				5'd0, revision_id};
		IDX_GEN_CFG: v = {62'd0, legacy_on, enabled};
		IDX_INT_STS: v[0] = irq_status;
		IDX_COUNTER: v = main_cnt & count_mask();
		IDX_T0_CFG: begin
			v[TCFG_LEVEL]    = level_mode;
			v[TCFG_INT_EN]   = irq_enable;
			v[TCFG_PERIODIC] = periodic_mode;
			v[TCFG_PER_CAP]  = 1'b1;
			v[TCFG_WIDE_CAP] = counter_wide;
			v[TCFG_VAL_SET]  = value_set;
		end
		IDX_T0_CMP:  v = cmp_val & count_mask();
		default: ;
		endcase
		return v;
	endfunction

	function automatic void register_write(input logic [IDX_W-1:0] idx,
			input logic [CNT_W-1:0] d);
		logic [CNT_W-1:0] m;
		m = count_mask();
		case (idx)
		IDX_GEN_CFG: begin
			enabled   = d[0];
			legacy_on = legacy_cap && d[1];
		end
		IDX_INT_STS: begin
			if (d[0])
				irq_status = 1'b0;
		end
		IDX_COUNTER: main_cnt = d & m;
		IDX_T0_CFG: begin
			level_mode    = d[TCFG_LEVEL];
			irq_enable    = d[TCFG_INT_EN];
			periodic_mode = d[TCFG_PERIODIC];
			value_set     = d[TCFG_VAL_SET];
		end
		IDX_T0_CMP: begin
			if (!periodic_mode || value_set)
				cmp_val = d & m;
			period_val = d & m;
			value_set  = 1'b0;
		end
		default: ;
		endcase
	endfunction

	function automatic result_t step_timer(input logic [ACT_W-1:0] act,
			input logic [IDX_W-1:0] idx, input logic [CNT_W-1:0] d);
		result_t          r;
		logic [CNT_W-1:0] m;
		m = count_mask();
		r = '0;
		case (act)
		ACT_TICK: begin
			if (enabled) begin
				main_cnt = (main_cnt + 64'd1) & m;
				if (main_cnt == (cmp_val & m)) begin
					r.matched  = 1'b1;
					irq_status = 1'b1;
					if (periodic_mode)
						cmp_val = (cmp_val + period_val) & m;
				end
			end
		end
		ACT_READ:  r.read_data = register_value(idx);
		ACT_WRITE: register_write(idx, d);
		default: ;
		endcase
		r.irq_level = irq_status && irq_enable;
		return r;
	endfunction

	task automatic check_reply(input logic [OUT_TDATA_W-1:0] bus);
		result_t want;
		if (timer_replies.size() == 0) begin
			$error("unexpected transaction on m_axis: %h", bus);
			mismatches++;
		end else begin
			want = timer_replies.pop_front();
			if (bus[CNT_W-1:0] !== want.read_data) begin
				$error("read_data: expected %h, actual %h", want.read_data, bus[CNT_W-1:0]);
				mismatches++;
			end
			if (bus[CNT_W] !== want.irq_level) begin
				$error("irq_level: expected %b, actual %b", want.irq_level, bus[CNT_W]);
				mismatches++;
			end
			if (bus[CNT_W+1] !== want.matched) begin
				$error("matched: expected %b, actual %b", want.matched, bus[CNT_W+1]);
				mismatches++;
			end
			if (bus[OUT_TDATA_W-1:CNT_W+2] !== '0) begin
				$error("pad: expected 0, actual %h", bus[OUT_TDATA_W-1:CNT_W+2]);
				mismatches++;
			end
		end
	endtask

	// replies are checked before the new transaction is predicted
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				check_reply(m_axis_tdata);
			if (s_axis_tvalid && s_axis_tready)
				timer_replies.push_back(step_timer(s_axis_tuser, s_axis_tdata[IDX_W-1:0],
						s_axis_tdata[IDX_W +: CNT_W]));
		end
	end

	always @(negedge clk) begin
		m_axis_tready <= no_gaps || ($urandom_range(0, 99) >= 16);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** event_timer_one_comparator_unit: FAILED **");
			$finish;
		end
	end

	function automatic bit take_gap();
		return !no_gaps && ($urandom_range(0, 99) < 16);
	endfunction

	// called and returns at a falling edge; tvalid stays high for the next call
	task automatic send_item(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] idx,
			input logic [CNT_W-1:0] d);
		while (take_gap()) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= act;
		s_axis_tdata  <= {PAD_W'(0), d, idx};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_replies();
		s_axis_tvalid <= 1'b0;
		while (timer_replies.size() != 0)
			@(negedge clk);
		@(negedge clk);
	endtask

	task automatic write_setting(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(negedge clk);
		apply_setting(index, value);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [IDX_W-1:0] pick_register();
		case ($urandom_range(0, 9))
		0:       return IDX_CAPS;
		1, 2:    return IDX_GEN_CFG;
		3:       return IDX_INT_STS;
		4, 5:    return IDX_COUNTER;
		6:       return IDX_T0_CFG;
		7, 8:    return IDX_T0_CMP;
		default: return IDX_W'($urandom);
		endcase
	endfunction

	// biased so that the counter often lands on the comparator
	task automatic send_random_item();
		int unsigned      pick;
		logic [CNT_W-1:0] m;
		logic [CNT_W-1:0] d;
		logic [IDX_W-1:0] idx;
		pick = $urandom_range(0, 99);
		m    = count_mask();
		d    = {$urandom, $urandom};
		idx  = pick_register();
		if (pick < 52) begin
			send_item(ACT_TICK, IDX_W'($urandom), d);
		end else if (pick < 66) begin
			send_item(ACT_READ, ($urandom_range(0, 3) == 0) ? IDX_W'($urandom) : idx, d);
		end else if (pick < 95) begin
			case (idx)
			IDX_GEN_CFG: d[0] = ($urandom_range(0, 9) != 0);
			IDX_COUNTER: begin
				case ($urandom_range(0, 3))
				0, 1: d = ((cmp_val - 64'($urandom_range(0, 6))) & m) | (~m & d);
				2:    d = (m - 64'($urandom_range(0, 4))) | (~m & d);
				default: ;
				endcase
			end
			IDX_T0_CMP: begin
				case ($urandom_range(0, 3))
				0, 1: d = ((main_cnt + 64'($urandom_range(1, 8))) & m) | (~m & d);
				2:    d = 64'($urandom_range(1, 8));
				default: ;
				endcase
			end
			default: ;
			endcase
			send_item(ACT_WRITE, idx, d);
		end else if (pick < 98) begin
			send_item(ACT_NONE, IDX_W'($urandom), d);
		end else begin
			send_item(ACT_WRITE, IDX_W'($urandom), d);
		end
	endtask

	task automatic test_reset_state();
		send_item(ACT_READ, IDX_CAPS, '0);
		send_item(ACT_READ, IDX_GEN_CFG, '0);
		send_item(ACT_READ, IDX_INT_STS, '0);
		send_item(ACT_READ, IDX_COUNTER, '0);
		send_item(ACT_READ, IDX_T0_CFG, '0);
		send_item(ACT_READ, IDX_T0_CMP, '0);
		send_item(ACT_READ, IDX_TOP, '1);
		send_item(ACT_NONE, IDX_TOP, '1);
		// disabled counter must not move
		send_item(ACT_TICK, IDX_TOP, '1);
	endtask

	task automatic test_register_map();
		send_item(ACT_WRITE, IDX_CAPS, '1);
		send_item(ACT_READ, IDX_CAPS, '0);
		send_item(ACT_WRITE, IDX_GEN_CFG, '1);
		send_item(ACT_READ, IDX_GEN_CFG, '0);
		send_item(ACT_WRITE, IDX_T0_CFG, '1);
		send_item(ACT_READ, IDX_T0_CFG, '0);
		// value set lets the comparator load; the second write only loads the period
		send_item(ACT_WRITE, IDX_T0_CMP, 64'd4);
		send_item(ACT_WRITE, IDX_T0_CMP, 64'd3);
		send_item(ACT_READ, IDX_T0_CMP, '0);
		send_item(ACT_WRITE, IDX_COUNTER, 64'd2);
		send_item(ACT_TICK, '0, '0);
		send_item(ACT_TICK, '0, '0);
		send_item(ACT_READ, IDX_INT_STS, '0);
		send_item(ACT_WRITE, IDX_INT_STS, 64'hFFFF_FFFF_FFFF_FFFE);
		send_item(ACT_WRITE, IDX_INT_STS, 64'd1);
		send_item(ACT_WRITE, IDX_SPARE, '1);
		send_item(ACT_WRITE, IDX_GEN_CFG, '0);
	endtask

	task automatic test_legacy_gate();
		send_item(ACT_WRITE, IDX_GEN_CFG, 64'd3);
		drain_replies();
		write_setting(CFG_LEGACY_CAP, '0);
		send_item(ACT_READ, IDX_GEN_CFG, '0);
		send_item(ACT_WRITE, IDX_GEN_CFG, 64'd2);
		send_item(ACT_READ, IDX_GEN_CFG, '0);
		drain_replies();
		write_setting(CFG_LEGACY_CAP, 27'h1);
	endtask

	task automatic test_narrow_counter();
		drain_replies();
		write_setting(CFG_WIDE_CNT, 27'h5A5A5A4);
		send_item(ACT_WRITE, IDX_T0_CFG, 64'(1) << TCFG_INT_EN);
		send_item(ACT_WRITE, IDX_T0_CMP, 64'hFFFF_FFFF_0000_0001);
		send_item(ACT_WRITE, IDX_COUNTER, '1);
		send_item(ACT_WRITE, IDX_GEN_CFG, 64'd1);
		send_item(ACT_TICK, '0, '0);
		send_item(ACT_TICK, '0, '0);
		send_item(ACT_READ, IDX_COUNTER, '0);
		send_item(ACT_READ, IDX_T0_CMP, '0);
		send_item(ACT_READ, IDX_T0_CFG, '0);
		send_item(ACT_WRITE, IDX_INT_STS, 64'd1);
	endtask

	task automatic test_setting_phases();
		int                  p;
		logic [PERIOD_W-1:0] period;
		logic                wide;
		logic                legacy;
		logic [VENDOR_W-1:0] vendor;
		logic [REV_W-1:0]    revision;
		for (p = 0; p < 8; p++) begin
			if (p == 0) begin
				period = 27'd1; wide = 1'b0; legacy = 1'b0; vendor = '0; revision = 8'd1;
			end else if (p == 1) begin
				period = 27'd100000000; wide = 1'b1; legacy = 1'b1; vendor = '1;
				revision = 8'd255;
			end else begin
				period   = PERIOD_W'($urandom_range(1, 100000000));
				wide     = 1'($urandom);
				legacy   = 1'($urandom);
				vendor   = VENDOR_W'($urandom);
				revision = REV_W'($urandom_range(1, 255));
			end
			// every reply is in before the settings change
			drain_replies();
			write_setting(CFG_TICK_PERIOD, period);
			write_setting(CFG_WIDE_CNT, {26'($urandom), wide});
			write_setting(CFG_LEGACY_CAP, {26'($urandom), legacy});
			write_setting(CFG_VENDOR, CFG_DATA_W'(vendor));
			write_setting(CFG_REVISION, CFG_DATA_W'(revision));
			if (p == 0)
				write_setting(CFG_SPARE, '1);
			no_gaps = (p == 2);
			repeat (PHASE_ITEMS)
				send_random_item();
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		reset_timer_model();
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_state();
		test_register_map();
		test_legacy_gate();
		test_narrow_counter();
		test_setting_phases();
		drain_replies();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("** event_timer_one_comparator_unit: PASSED **");
		else
			$display("** event_timer_one_comparator_unit: FAILED **");
		$finish;
	end

endmodule

FILE: event_timer_one_comparator_unit.f
sv/etm_pkg.sv
sv/etm_core.sv
sv/event_timer_one_comparator_unit.sv
test/tb_event_timer_one_comparator_unit.sv
